// ===== sv/btkh_pkg.sv =====
`default_nettype none

package btkh_pkg;

   // Storage depth and derived index widths
   localparam int DEPTH    = 1024;
   localparam int IDX_W    = $clog2(DEPTH + 1);
   localparam int ADDR_W   = $clog2(DEPTH);

   // Fixed field widths
   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 11;
   localparam int CAP_W    = 11;
   localparam int CMP_W    = (IDX_W > CAP_W) ? IDX_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

   // Request action codes
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_REJECTED = 3'd1,
      ST_EVICTED  = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Heap store access for one cycle
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr_a;
      logic [ADDR_W-1:0] rd_addr_b;
   } ram_req_type;

endpackage

`default_nettype wire

// ===== sv/btkh_req_if.sv =====
`default_nettype none

interface btkh_req_if;
   import btkh_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [KEY_W-1:0]    item_key;
   logic [HANDLE_W-1:0] item_handle;

   modport source (output valid, action, item_key, item_handle, input ready);
   modport sink   (input valid, action, item_key, item_handle, output ready);
endinterface

`default_nettype wire

// ===== sv/btkh_rsp_if.sv =====
`default_nettype none

interface btkh_rsp_if;
   import btkh_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [KEY_W-1:0]    out_key;
   logic [HANDLE_W-1:0] out_handle;
   logic                out_valid;
   logic [KEY_W-1:0]    min_key;
   logic [HANDLE_W-1:0] min_handle;
   logic [CNT_W-1:0]    count;
   logic                is_empty;

   modport source (output valid, status, out_key, out_handle, out_valid, min_key,
                   min_handle, count, is_empty, input ready);
   modport sink   (input valid, status, out_key, out_handle, out_valid, min_key,
                   min_handle, count, is_empty, output ready);
endinterface

`default_nettype wire

// ===== sv/btkh_csr_if.sv =====
`default_nettype none

interface btkh_csr_if;
   import btkh_pkg::*;

   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

`default_nettype wire

// ===== sv/btkh_ram.sv =====
`default_nettype none

module btkh_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register both read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== sv/btkh_ctrl.sv =====
`default_nettype none

module btkh_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   btkh_req_if.sink                         req_ch,
   btkh_rsp_if.source                       rsp_ch,
   input  wire logic [btkh_pkg::CMP_W-1:0]  eff_cap,
   output      btkh_pkg::ram_req_type       ram_req,
   input  wire btkh_pkg::entry_type         rd_data_a,
   input  wire btkh_pkg::entry_type         rd_data_b
);
   import btkh_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DL_LAST,
      S_DL_LOOP,
      S_DL_TAIL,
      S_UP_START,
      S_UP_LOOP,
      S_UP_TAIL,
      S_DONE
   } state_type;

   localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(DEPTH);

   state_type         state_ff,  state_in;
   logic [IDX_W-1:0]  count_ff,  count_in;
   logic [IDX_W-1:0]  pos_ff,    pos_in;
   entry_type         root_ff,   root_in;
   entry_type         last_ff,   last_in;
   entry_type         new_ff,    new_in;
   logic              evict_ff,  evict_in;
   status_type        status_ff, status_in;
   entry_type         out_ff,    out_in;
   logic              outv_ff,   outv_in;

   logic              rsp_valid_ff,  rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   entry_type         rsp_out_ff,    rsp_out_in;
   logic              rsp_outv_ff,   rsp_outv_in;
   entry_type         rsp_min_ff,    rsp_min_in;
   logic [CNT_W-1:0]  rsp_count_ff,  rsp_count_in;
   logic              rsp_empty_ff,  rsp_empty_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   entry_type         wr_data;
   logic [IDX_W-1:0]  rd_idx_a;
   logic [IDX_W-1:0]  rd_idx_b;

   logic              full;
   state_type         after_del;
   logic [IDX_W:0]    child;
   logic [IDX_W:0]    grand;
   logic              use_b;
   entry_type         sel;
   logic [IDX_W-1:0]  sel_idx;
   logic [IDX_W-1:0]  parent;
   logic [IDX_W-1:0]  n_after;

   assign full      = CMP_W'(count_ff) >= eff_cap;
   assign after_del = evict_ff ? S_UP_START : S_DONE;
   assign n_after   = count_ff - IDX_ONE;

   // Sift-down child choice: smaller child, left wins ties
   assign child   = {pos_ff, 1'b0};
   assign use_b   = (child != {1'b0, count_ff}) && (rd_data_b.key < rd_data_a.key);
   assign sel     = use_b ? rd_data_b : rd_data_a;
   assign sel_idx = child[IDX_W-1:0] | IDX_W'(use_b);
   assign grand   = {sel_idx, 1'b0};
   assign parent  = pos_ff >> 1;

   // Sequencer next state and store access
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      last_in       = last_ff;
      new_in        = new_ff;
      evict_in      = evict_ff;
      status_in     = status_ff;
      out_in        = out_ff;
      outv_in       = outv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_out_in    = rsp_out_ff;
      rsp_outv_in   = rsp_outv_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_idx        = pos_ff;
      wr_data       = new_ff;
      rd_idx_a      = count_ff;
      rd_idx_b      = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               new_in   = '{key: req_ch.item_key, handle: req_ch.item_handle};
               out_in   = '0;
               outv_in  = 1'b0;
               evict_in = 1'b0;
               case (req_ch.action)
                  ACT_INSERT: begin
                     if (!full) begin
                        status_in = ST_INSERTED;
                        state_in  = S_UP_START;
                     end else if (req_ch.item_key < root_ff.key) begin
                        status_in = ST_REJECTED;
                        state_in  = S_DONE;
                     end else begin
                        // Evict the root first, then insert
                        status_in = ST_EVICTED;
                        evict_in  = 1'b1;
                        rd_idx_a  = count_ff;
                        state_in  = S_DL_LAST;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        status_in = ST_REMOVED;
                        rd_idx_a  = count_ff;
                        state_in  = S_DL_LAST;
                     end
                  end
                  default: begin
                     status_in = (count_ff == '0) ? ST_EMPTY : ST_INSERTED;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         S_DL_LAST: begin
            // Take the last entry and report the root
            last_in  = rd_data_a;
            out_in   = root_ff;
            outv_in  = 1'b1;
            count_in = n_after;
            pos_in   = IDX_ONE;
            if ({1'b0, n_after} >= (IDX_W + 1)'(2)) begin
               rd_idx_a = IDX_W'(2);
               rd_idx_b = IDX_W'(3);
               state_in = S_DL_LOOP;
            end else begin
               // Nothing to place when the heap has just emptied
               wr_en    = (n_after != '0);
               wr_idx   = IDX_ONE;
               wr_data  = rd_data_a;
               state_in = after_del;
            end
         end

         S_DL_LOOP: begin
            wr_en = 1'b1;
            if (last_ff.key > sel.key) begin
               // Move the child up one level and descend
               wr_data = sel;
               pos_in  = sel_idx;
               if (grand <= {1'b0, count_ff}) begin
                  rd_idx_a = grand[IDX_W-1:0];
                  rd_idx_b = grand[IDX_W-1:0] | IDX_ONE;
               end else begin
                  state_in = S_DL_TAIL;
               end
            end else begin
               wr_data  = last_ff;
               state_in = after_del;
            end
         end

         S_DL_TAIL: begin
            wr_en    = 1'b1;
            wr_data  = last_ff;
            state_in = after_del;
         end

         S_UP_START: begin
            count_in = count_ff + IDX_ONE;
            pos_in   = count_ff + IDX_ONE;
            if (count_ff == '0) begin
               wr_en    = 1'b1;
               wr_idx   = IDX_ONE;
               state_in = S_DONE;
            end else begin
               rd_idx_a = (count_ff + IDX_ONE) >> 1;
               state_in = S_UP_LOOP;
            end
         end

         S_UP_LOOP: begin
            wr_en = 1'b1;
            if (rd_data_a.key > new_ff.key) begin
               // Pull the parent down and climb
               wr_data = rd_data_a;
               pos_in  = parent;
               if (parent > IDX_ONE) begin
                  rd_idx_a = parent >> 1;
               end else begin
                  state_in = S_UP_TAIL;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         S_UP_TAIL: begin
            wr_en    = 1'b1;
            state_in = S_DONE;
         end

         S_DONE: begin
            // Load the result once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_out_in    = out_ff;
               rsp_outv_in   = outv_ff;
               rsp_min_in    = (count_ff != '0) ? root_ff : '0;
               rsp_count_in  = CNT_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Shadow the root entry
      root_in = (wr_en && wr_idx == IDX_ONE) ? wr_data : root_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      root_ff       <= root_in;
      last_ff       <= last_in;
      new_ff        <= new_in;
      evict_ff      <= evict_in;
      status_ff     <= status_in;
      out_ff        <= out_in;
      outv_ff       <= outv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_out_ff    <= rsp_out_in;
      rsp_outv_ff   <= rsp_outv_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // Heap index to store address
   assign ram_req.wr_en     = wr_en;
   assign ram_req.wr_addr   = ADDR_W'(wr_idx - IDX_ONE);
   assign ram_req.wr_data   = wr_data;
   assign ram_req.rd_addr_a = ADDR_W'(rd_idx_a - IDX_ONE);
   assign ram_req.rd_addr_b = ADDR_W'(rd_idx_b - IDX_ONE);

   assign req_ch.ready      = (state_ff == S_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.out_key    = rsp_out_ff.key;
   assign rsp_ch.out_handle = rsp_out_ff.handle;
   assign rsp_ch.out_valid  = rsp_outv_ff;
   assign rsp_ch.min_key    = rsp_min_ff.key;
   assign rsp_ch.min_handle = rsp_min_ff.handle;
   assign rsp_ch.count      = rsp_count_ff;
   assign rsp_ch.is_empty   = rsp_empty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_DEPTH)
      else $error("entry count beyond depth");

   a_write_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_idx != '0 && wr_idx <= count_in))
      else $error("heap write outside held entries");

   a_root_shadow: assert property (@(posedge clock) disable iff (reset)
      (wr_en && wr_idx == IDX_ONE) |=> (root_ff == $past(wr_data)))
      else $error("root shadow out of step with store");

   a_sift_children: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DL_LOOP) |-> (count_ff >= IDX_W'(2)))
      else $error("sift-down with no children");

   a_out_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outv_ff) |->
         (rsp_status_ff == ST_EVICTED || rsp_status_ff == ST_REMOVED))
      else $error("entry reported without removal");

endmodule

`default_nettype wire

// ===== sv/bounded_top_k_min_heap.sv =====
`default_nettype none

// Top-K keeper on a binary min-heap of (key, handle) pairs held in one
// dual-read, single-write synchronous memory; the root is mirrored in a
// register. One item is in work at a time and gives exactly one result.
// Peek, a rejected insert and delete on an empty heap touch no memory. An
// insert below capacity climbs the new entry level by level; delete-min
// sinks the last entry level by level; an evicting insert runs both. The
// sift loops pace the work: each level needs the registered read of the
// level before it to choose the next address. The output register lets a
// new item be accepted while a result waits. Capacity is to be written by
// the user only while the block is idle; the block itself does not enforce
// this. No clearing pass follows reset, and the heap is empty after reset.
module bounded_top_k_min_heap (
   input wire logic   clock,
   input wire logic   reset,
   btkh_req_if.sink   req_ch,
   btkh_rsp_if.source rsp_ch,
   btkh_csr_if.sink   csr_ch
);
   import btkh_pkg::*;

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic [CMP_W-1:0] eff_cap;
   ram_req_type      ram_req;
   logic [ENTRY_W-1:0] rd_raw_a;
   logic [ENTRY_W-1:0] rd_raw_b;
   entry_type        rd_data_a;
   entry_type        rd_data_b;

   // Capacity register
   assign csr_ch.ready = 1'b1;
   assign capacity_in  = csr_ch.valid ? csr_ch.capacity : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Clamp capacity to one through the depth
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = CMP_W'(capacity_ff);
      end
   end

   assign rd_data_a = rd_raw_a;
   assign rd_data_b = rd_raw_b;

   btkh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (ram_req.wr_en),
      .wr_addr   (ram_req.wr_addr),
      .wr_data   (ram_req.wr_data),
      .rd_addr_a (ram_req.rd_addr_a),
      .rd_data_a (rd_raw_a),
      .rd_addr_b (ram_req.rd_addr_b),
      .rd_data_b (rd_raw_b)
   );

   btkh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .eff_cap   (eff_cap),
      .ram_req   (ram_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule

`default_nettype wire

// ===== verif/tb_bounded_top_k_min_heap.sv =====
`timescale 1ns / 1ps

module tb_bounded_top_k_min_heap;
   import btkh_pkg::*;

   // Action code with no operation of its own; the block treats it as peek
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int TAIL_CYCLES = 40;

   typedef struct packed {
      status_type          status;
      logic [KEY_W-1:0]    out_key;
      logic [HANDLE_W-1:0] out_handle;
      logic                out_valid;
      logic [KEY_W-1:0]    min_key;
      logic [HANDLE_W-1:0] min_handle;
      logic [CNT_W-1:0]    count;
      logic                is_empty;
   } heap_report_type;

   logic clock = 1'b0;
   logic reset;

   btkh_req_if req_ch ();
   btkh_rsp_if rsp_ch ();
   btkh_csr_if csr_ch ();

   bounded_top_k_min_heap DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Mirror of the heap: slot 1 is the root
   logic [KEY_W-1:0]    mirror_key    [1:DEPTH];
   logic [HANDLE_W-1:0] mirror_handle [1:DEPTH];
   int                  mirror_count;
   logic [CAP_W-1:0]    mirror_cap;

   heap_report_type awaited_reports [$];
   int              fail_count;
   int              cycle_count;
   int              stall_cycles;
   bit              steady_run;

   // Take the root out and sink the last entry into place
   function automatic void mirror_pop(output logic [KEY_W-1:0] k,
                                      output logic [HANDLE_W-1:0] h);
      int                  i;
      int                  child;
      int                  n;
      bit                  settled;
      logic [KEY_W-1:0]    last_k;
      logic [HANDLE_W-1:0] last_h;
      k       = mirror_key[1];
      h       = mirror_handle[1];
      last_k  = mirror_key[mirror_count];
      last_h  = mirror_handle[mirror_count];
      mirror_count--;
      n       = mirror_count;
      i       = 1;
      settled = 1'b0;
      while (!settled && i * 2 <= n) begin
         child = i * 2;
         if (child != n && mirror_key[child + 1] < mirror_key[child]) child++;
         if (last_k > mirror_key[child]) begin
            mirror_key[i]    = mirror_key[child];
            mirror_handle[i] = mirror_handle[child];
            i                = child;
         end else begin
            settled = 1'b1;
         end
      end
      mirror_key[i]    = last_k;
      mirror_handle[i] = last_h;
   endfunction

   // Append and climb; strict compare leaves an equal parent in place
   function automatic void mirror_push(input logic [KEY_W-1:0] k,
                                       input logic [HANDLE_W-1:0] h);
      int i;
      mirror_count++;
      i = mirror_count;
      while (i > 1 && mirror_key[i / 2] > k) begin
         mirror_key[i]    = mirror_key[i / 2];
         mirror_handle[i] = mirror_handle[i / 2];
         i                = i / 2;
      end
      mirror_key[i]    = k;
      mirror_handle[i] = h;
   endfunction

   // Apply one operation to the mirror and build the report it should give
   function automatic heap_report_type model_heap_op(input logic [ACTION_W-1:0] act,
                                                     input logic [KEY_W-1:0]    k,
                                                     input logic [HANDLE_W-1:0] h);
      heap_report_type     r;
      int                  cap;
      logic [KEY_W-1:0]    gone_k;
      logic [HANDLE_W-1:0] gone_h;
      r      = '0;
      gone_k = '0;
      gone_h = '0;
      cap    = int'(mirror_cap);
      if (cap == 0) cap = 1;
      if (cap > DEPTH) cap = DEPTH;
      case (act)
         ACT_INSERT: begin
            if (mirror_count >= cap) begin
               if (k < mirror_key[1]) begin
                  r.status = ST_REJECTED;
               end else begin
                  mirror_pop(gone_k, gone_h);
                  mirror_push(k, h);
                  r.out_valid = 1'b1;
                  r.status    = ST_EVICTED;
               end
            end else begin
               mirror_push(k, h);
               r.status = ST_INSERTED;
            end
         end
         ACT_DELETE: begin
            if (mirror_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               mirror_pop(gone_k, gone_h);
               r.out_valid = 1'b1;
               r.status    = ST_REMOVED;
            end
         end
         default: begin
            r.status = (mirror_count == 0) ? ST_EMPTY : ST_INSERTED;
         end
      endcase
      r.out_key    = gone_k;
      r.out_handle = gone_h;
      r.min_key    = (mirror_count != 0) ? mirror_key[1] : '0;
      r.min_handle = (mirror_count != 0) ? mirror_handle[1] : '0;
      r.count      = CNT_W'(mirror_count);
      r.is_empty   = (mirror_count == 0);
      return r;
   endfunction

   // Offer one item, wait for acceptance and record its expected report
   task automatic issue_op(input logic [ACTION_W-1:0] act,
                           input logic [KEY_W-1:0]    k,
                           input logic [HANDLE_W-1:0] h);
      if (!steady_run && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.item_key    <= k;
      req_ch.item_handle <= h;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      awaited_reports.push_back(model_heap_op(act, k, h));
   endtask

   // Drop valid and hold until every report is back
   task automatic settle_heap();
      req_ch.valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      settle_heap();
      csr_ch.valid    <= 1'b1;
      csr_ch.capacity <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      mirror_cap = value;
   endtask

   // Mix of wide, clustered, extreme and near-minimum keys
   function automatic logic [KEY_W-1:0] pick_key();
      int unsigned      sel;
      logic [KEY_W-1:0] k;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         k = $urandom;
      end else if (sel < 70) begin
         k = $urandom_range(0, 15);
      end else if (sel < 80) begin
         k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      end else if (mirror_count == 0) begin
         k = $urandom;
      end else begin
         k = mirror_key[1] + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
      end
      return k;
   endfunction

   task automatic run_random(input int n, input int ins_pct, input int del_pct);
      int unsigned          sel;
      logic [ACTION_W-1:0]  act;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < ins_pct) act = ACT_INSERT;
         else if (sel < ins_pct + del_pct) act = ACT_DELETE;
         else act = ($urandom_range(0, 1) != 0) ? ACT_PEEK : ACT_UNUSED;
         issue_op(act, pick_key(), HANDLE_W'($urandom_range(0, 65535)));
      end
   endtask

   // Delete, peek and the unused code on an empty heap
   task automatic test_empty_heap();
      issue_op(ACT_PEEK, '1, '1);
      issue_op(ACT_DELETE, '0, '0);
      issue_op(ACT_UNUSED, '1, '0);
   endtask

   task automatic test_extreme_keys();
      issue_op(ACT_INSERT, '1, '1);
      issue_op(ACT_INSERT, '0, '0);
      issue_op(ACT_UNUSED, 32'h1234_5678, 16'h00FF);
      issue_op(ACT_DELETE, '0, '0);
      issue_op(ACT_DELETE, '0, '0);
      issue_op(ACT_DELETE, '0, '0);
   endtask

   // Equal keys: three inserts of one key, then three deletes
   task automatic test_equal_keys();
      issue_op(ACT_INSERT, 32'd5, 16'd1);
      issue_op(ACT_INSERT, 32'd5, 16'd2);
      issue_op(ACT_INSERT, 32'd5, 16'd3);
      repeat (3) issue_op(ACT_DELETE, '0, '0);
   endtask

   // Capacity one: reject below, evict on a key equal to the minimum
   task automatic test_unit_capacity();
      write_capacity(CAP_W'(1));
      issue_op(ACT_INSERT, 32'd10, 16'd1);
      issue_op(ACT_INSERT, 32'd9, 16'd2);
      issue_op(ACT_INSERT, 32'd10, 16'd3);
      issue_op(ACT_DELETE, '0, '0);
   endtask

   // Capacity zero acts as one
   task automatic test_zero_capacity();
      write_capacity(CAP_W'(0));
      issue_op(ACT_INSERT, 32'd3, 16'd5);
      issue_op(ACT_INSERT, '1, 16'd6);
   endtask

   // Capacity lowered under the count: the count must hold steady
   task automatic test_capacity_below_count();
      write_capacity(CAP_W'(8));
      issue_op(ACT_INSERT, 32'd100, 16'd7);
      issue_op(ACT_INSERT, 32'd200, 16'd8);
      issue_op(ACT_INSERT, 32'd300, 16'd9);
      write_capacity(CAP_W'(2));
      issue_op(ACT_INSERT, 32'd50, 16'd10);
      issue_op(ACT_INSERT, 32'd150, 16'd11);
   endtask

   task automatic test_random_small_caps();
      write_capacity(CAP_W'(1));
      run_random(60, 50, 35);
      write_capacity(CAP_W'(5));
      run_random(100, 50, 35);
      write_capacity(CAP_W'(0));
      run_random(40, 55, 30);
      write_capacity(CAP_W'(40));
      run_random(150, 60, 30);
   endtask

   // All-ones capacity saturates at the full depth; fill it and keep going
   task automatic test_random_full_depth();
      write_capacity('1);
      run_random(1100, 96, 2);
   endtask

   // Small capacity over a nearly full heap, no idling on either side
   task automatic test_random_shrunk_steady();
      write_capacity(CAP_W'(3));
      steady_run = 1'b1;
      run_random(100, 60, 35);
   endtask

   // Drive result ready with random stall bursts
   always @(posedge clock) begin
      if (reset || steady_run) begin
         rsp_ch.ready <= 1'b1;
         stall_cycles <= 0;
      end else if (stall_cycles != 0) begin
         stall_cycles <= stall_cycles - 1;
         rsp_ch.ready <= (stall_cycles == 1);
      end else if ($urandom_range(0, 9) == 0) begin
         stall_cycles <= $urandom_range(1, 19);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted report with the oldest expectation
   always @(posedge clock) begin
      heap_report_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (awaited_reports.size() == 0) begin
            $error("report with no expectation: status %0d count %0d",
                   rsp_ch.status, rsp_ch.count);
            fail_count++;
         end else begin
            want = awaited_reports.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               fail_count++;
            end
            if (rsp_ch.out_key !== want.out_key) begin
               $error("out_key: expected %0h, actual %0h", want.out_key, rsp_ch.out_key);
               fail_count++;
            end
            if (rsp_ch.out_handle !== want.out_handle) begin
               $error("out_handle: expected %0h, actual %0h",
                      want.out_handle, rsp_ch.out_handle);
               fail_count++;
            end
            if (rsp_ch.out_valid !== want.out_valid) begin
               $error("out_valid: expected %0d, actual %0d",
                      want.out_valid, rsp_ch.out_valid);
               fail_count++;
            end
            if (rsp_ch.min_key !== want.min_key) begin
               $error("min_key: expected %0h, actual %0h", want.min_key, rsp_ch.min_key);
               fail_count++;
            end
            if (rsp_ch.min_handle !== want.min_handle) begin
               $error("min_handle: expected %0h, actual %0h",
                      want.min_handle, rsp_ch.min_handle);
               fail_count++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
               fail_count++;
            end
            if (rsp_ch.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_ch.is_empty);
               fail_count++;
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("bounded_top_k_min_heap test failed");
      $finish;
   end

   initial begin
      int guard;
      fail_count   = 0;
      steady_run   = 1'b0;
      mirror_count = 0;
      mirror_cap   = CAP_RESET;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACT_PEEK;
      req_ch.item_key    <= '0;
      req_ch.item_handle <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.capacity    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_heap();
      test_extreme_keys();
      test_equal_keys();
      test_unit_capacity();
      test_zero_capacity();
      test_capacity_below_count();
      test_random_small_caps();
      test_random_full_depth();
      test_random_shrunk_steady();

      // Drain the last reports, then give the block time to go quiet
      req_ch.valid <= 1'b0;
      guard = 0;
      while (awaited_reports.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_reports.size() != 0) begin
         $error("%0d expected reports never arrived", awaited_reports.size());
         fail_count++;
      end

      if (fail_count == 0) begin
         $display("bounded_top_k_min_heap test passed");
      end else begin
         $display("bounded_top_k_min_heap test failed");
      end
      $finish;
   end

endmodule
